/* sv/rvmd_pkg.sv */
package rvmd_pkg;

    localparam logic [2:0] FUNC_MUL    = 3'd0;
    localparam logic [2:0] FUNC_MULH   = 3'd1;
    localparam logic [2:0] FUNC_MULHSU = 3'd2;
    localparam logic [2:0] FUNC_MULHU  = 3'd3;
    localparam logic [2:0] FUNC_DIV    = 3'd4;
    localparam logic [2:0] FUNC_DIVU   = 3'd5;
    localparam logic [2:0] FUNC_REM    = 3'd6;
    localparam logic [2:0] FUNC_REMU   = 3'd7;

    // classification decided in the front end
    typedef struct packed {
        logic is_div;     // divide/remainder, else multiply
        logic want_high;  // high product / remainder
        logic neg_res;    // negate the magnitude result
        logic special;    // divide by zero or signed overflow
    } rvmd_cls_t;

endpackage

/* sv/rvmd_front.sv */
module rvmd_front #(
    parameter int XLEN = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2:0]          func,
    input  logic [XLEN-1:0]     operand_a,
    input  logic [XLEN-1:0]     operand_b,
    output logic                q_valid,
    output rvmd_pkg::rvmd_cls_t q_cls,
    output logic [XLEN-1:0]     q_ma,
    output logic [XLEN-1:0]     q_mb,
    output logic [XLEN-1:0]     q_spec
);

    logic                valid_reg;
    rvmd_pkg::rvmd_cls_t cls_reg, cls_next;
    logic [XLEN-1:0]     ma_reg, ma_next, mb_reg, mb_next, spec_reg, spec_next;

    always_comb
    begin
        logic sa, sb, sa_use, sb_use, bzero, ovf;
        sa = operand_a[XLEN-1];
        sb = operand_b[XLEN-1];
        sa_use = 1'b0;
        sb_use = 1'b0;
        unique case (func)
            rvmd_pkg::FUNC_MULH, rvmd_pkg::FUNC_DIV, rvmd_pkg::FUNC_REM:
            begin
                sa_use = sa;
                sb_use = sb;
            end
            rvmd_pkg::FUNC_MULHSU:
                sa_use = sa;
            default:
            begin
                sa_use = 1'b0;
                sb_use = 1'b0;
            end
        endcase
        bzero = (operand_b == '0);
        ovf = (operand_a == {1'b1, {(XLEN-1){1'b0}}}) && (operand_b == '1);
        ma_next = sa_use ? (~operand_a + 1'b1) : operand_a;
        mb_next = sb_use ? (~operand_b + 1'b1) : operand_b;
        cls_next.is_div = func[2];
        cls_next.want_high = func[2] ? func[1] : (func[1:0] != 2'd0);
        if (func[2] && func[1])
            cls_next.neg_res = sa_use;
        else
            cls_next.neg_res = sa_use ^ sb_use;
        spec_next = '0;
        cls_next.special = 1'b0;
        if (func[2] && bzero)
        begin
            cls_next.special = 1'b1;
            spec_next = func[1] ? operand_a : '1;
        end
        else if ((func == rvmd_pkg::FUNC_DIV || func == rvmd_pkg::FUNC_REM) && ovf)
        begin
            cls_next.special = 1'b1;
            spec_next = func[1] ? '0 : operand_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            cls_reg  <= cls_next;
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
            spec_reg <= spec_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_cls   = cls_reg;
    assign q_ma    = ma_reg;
    assign q_mb    = mb_reg;
    assign q_spec  = spec_reg;

endmodule

/* sv/rvmd_back.sv */
module rvmd_back #(
    parameter int XLEN = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  rvmd_pkg::rvmd_cls_t q_cls,
    input  logic [XLEN-1:0]     q_ma,
    input  logic [XLEN-1:0]     q_mb,
    input  logic [XLEN-1:0]     q_spec,
    output logic                done,
    output logic [XLEN-1:0]     result
);

    // XLEN-stage restoring divider, one quotient bit per stage; the first four
    // stages also build the product from half-word partial products.
    localparam int STAGES = XLEN;
    localparam int HW = XLEN / 2;

    logic                valid_reg [STAGES+1];
    rvmd_pkg::rvmd_cls_t cls_reg   [STAGES+1];
    logic [XLEN-1:0]     spec_reg  [STAGES+1];
    logic [XLEN-1:0]     den_reg   [STAGES+1];
    logic [XLEN-1:0]     quo_reg   [STAGES+1];
    logic [XLEN-1:0]     rem_reg   [STAGES+1];
    logic [2*XLEN-1:0]   prod_reg  [STAGES+1];

    assign valid_reg[0] = q_valid;
    assign cls_reg[0]   = q_cls;
    assign spec_reg[0]  = q_spec;
    assign den_reg[0]   = q_mb;
    assign quo_reg[0]   = q_ma;
    assign rem_reg[0]   = '0;
    assign prod_reg[0]  = '0;

    // multiply: stage 0..3 accumulate one half-by-half partial product each;
    // division: one quotient bit per stage
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [XLEN+1:0]   trial;
        logic [XLEN:0]     rem_sh;
        logic [2*XLEN-1:0] prod_next;
        logic [XLEN-1:0]   pp;
        always_comb
        begin
            // partial remainder may use the full XLEN bits before the shift
            rem_sh = {rem_reg[s], quo_reg[s][XLEN-1]};
            trial = {1'b0, rem_sh} - {2'b00, den_reg[s]};
            pp = '0;
            prod_next = prod_reg[s];
            if (s < 4)
            begin
                unique case (s % 4)
                    0: pp = XLEN'(q_ma[HW-1:0]) * XLEN'(q_mb[HW-1:0]);
                    1: pp = XLEN'(quo_reg[s][HW-1:0]) * XLEN'(den_reg[s][XLEN-1:HW]);
                    2: pp = XLEN'(quo_reg[s][XLEN-1:HW]) * XLEN'(den_reg[s][HW-1:0]);
                    default:
                        pp = XLEN'(quo_reg[s][XLEN-1:HW]) * XLEN'(den_reg[s][XLEN-1:HW]);
                endcase
                unique case (s % 4)
                    0: prod_next = (2*XLEN)'(pp);
                    1, 2: prod_next = prod_reg[s] + ((2*XLEN)'(pp) << HW);
                    default: prod_next = prod_reg[s] + ((2*XLEN)'(pp) << XLEN);
                endcase
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s+1] <= 1'b0;
            else
                valid_reg[s+1] <= valid_reg[s];
        end
        always_ff @(posedge clk)
        begin
            cls_reg[s+1]  <= cls_reg[s];
            spec_reg[s+1] <= spec_reg[s];
            den_reg[s+1]  <= den_reg[s];
            prod_reg[s+1] <= prod_next;
            if (cls_reg[s].is_div)
            begin
                if (!trial[XLEN+1])
                begin
                    rem_reg[s+1] <= trial[XLEN-1:0];
                    quo_reg[s+1] <= {quo_reg[s][XLEN-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1] <= rem_sh[XLEN-1:0];
                    quo_reg[s+1] <= {quo_reg[s][XLEN-2:0], 1'b0};
                end
            end
            else
            begin
                rem_reg[s+1] <= rem_reg[s];
                quo_reg[s+1] <= quo_reg[s];
            end
        end
    end

    logic [XLEN-1:0]   mag, res_full;
    logic [2*XLEN-1:0] prod_s;
    logic              done_reg;
    logic [XLEN-1:0]   result_reg;

    always_comb
    begin
        prod_s = cls_reg[STAGES].neg_res ? (~prod_reg[STAGES] + 1'b1) : prod_reg[STAGES];
        if (cls_reg[STAGES].is_div)
        begin
            mag = cls_reg[STAGES].want_high ? rem_reg[STAGES] : quo_reg[STAGES];
            res_full = cls_reg[STAGES].neg_res ? (~mag + 1'b1) : mag;
        end
        else
        begin
            mag = '0;
            res_full = cls_reg[STAGES].want_high ? prod_s[2*XLEN-1:XLEN] : prod_s[XLEN-1:0];
        end
        if (cls_reg[STAGES].special)
            res_full = spec_reg[STAGES];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_reg[STAGES];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_full;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* sv/rv_mul_div_unit.sv */
// done strobes once the start beat has passed the front register, the XLEN
// divider stage registers and the output registers; result is valid with done.
// Throughput: one operation per cycle; busy is never raised.
// Front end classifies and takes magnitudes, back end is an XLEN-stage
// restoring divider pipeline that also carries the multiply partial products.
// Reset (rst_n, async, active low) clears all valid flags; the receiver cannot stall.
module rv_mul_div_unit #(
    parameter int XLEN = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [2:0]      func,
    input  logic [XLEN-1:0] operand_a,
    input  logic [XLEN-1:0] operand_b,
    output logic            done,
    output logic [XLEN-1:0] result
);

    logic                q_valid;
    rvmd_pkg::rvmd_cls_t q_cls;
    logic [XLEN-1:0]     q_ma, q_mb, q_spec;

    assign busy = 1'b0;

    rvmd_front #(.XLEN(XLEN)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .q_valid   (q_valid),
        .q_cls     (q_cls),
        .q_ma      (q_ma),
        .q_mb      (q_mb),
        .q_spec    (q_spec)
    );

    rvmd_back #(.XLEN(XLEN)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cls   (q_cls),
        .q_ma    (q_ma),
        .q_mb    (q_mb),
        .q_spec  (q_spec),
        .done    (done),
        .result  (result)
    );

`ifndef NO_ASSERTIONS
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_front: assert property (@(posedge clk) disable iff (!rst_n) start |=> q_valid)
        else $error("front lost a beat");
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n) !q_valid |-> ##(XLEN+1) !done)
        else $error("result strobe without a beat");
`endif

endmodule

/* tb/rvmd_checker.sv */
`timescale 1ns / 100ps

module rvmd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  func,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic        done,
    input  logic [31:0] result,
    output int          fail_count,
    output int          pending
);

    logic [31:0] expected_results[$];

    function automatic logic [31:0] abs32(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic logic [31:0] md_predict(logic [2:0] f, logic [31:0] a, logic [31:0] b);
        logic [63:0] prod;
        logic [31:0] q;
        logic        neg;
        case (f)
            rvmd_pkg::FUNC_MUL: return a * b;
            rvmd_pkg::FUNC_MULH:
            begin
                prod = {32'd0, abs32(a)} * {32'd0, abs32(b)};
                neg = a[31] ^ b[31];
                return neg ? (~prod[63:32] + (prod[31:0] == 0)) : prod[63:32];
            end
            rvmd_pkg::FUNC_MULHSU:
            begin
                prod = {32'd0, abs32(a)} * {32'd0, b};
                return a[31] ? (~prod[63:32] + (prod[31:0] == 0)) : prod[63:32];
            end
            rvmd_pkg::FUNC_MULHU:
            begin
                prod = {32'd0, a} * {32'd0, b};
                return prod[63:32];
            end
            rvmd_pkg::FUNC_DIV:
            begin
                if (b == 0) return '1;
                q = abs32(a) / abs32(b);
                return (a[31] ^ b[31]) ? -q : q;
            end
            rvmd_pkg::FUNC_DIVU: return (b == 0) ? '1 : a / b;
            rvmd_pkg::FUNC_REM:
            begin
                if (b == 0) return a;
                q = abs32(a) % abs32(b);
                return a[31] ? -q : q;
            end
            default: return (b == 0) ? a : a % b;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] exp_val;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_results.push_back(md_predict(func, operand_a, operand_b));
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result beat: %h", result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_val = expected_results.pop_front();
                    if (exp_val !== result)
                    begin
                        if (fail_count < 10)
                            $display("result mismatch: expected %h actual %h", exp_val, result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  func;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        done;
    logic [31:0] result;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;

    rv_mul_div_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .operand_a(operand_a), .operand_b(operand_b), .done(done), .result(result)
    );

    rvmd_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .operand_a(operand_a), .operand_b(operand_b), .done(done), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 15);
            5: return -$urandom_range(1, 15);
            default: return $urandom;
        endcase
    endfunction

    // holds one beat until accepted; start stays high across back-to-back beats
    task automatic issue(logic [2:0] f, logic [31:0] a, logic [31:0] b);
        start = 1'b1;
        func = f;
        operand_a = a;
        operand_b = b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic gap(int n);
        start = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    initial
    begin
        int burst;
        int sent;
        int waited;
        logic [31:0] sample_a[4];
        logic [31:0] sample_b[4];

        start = 1'b0;
        func = rvmd_pkg::FUNC_MUL;
        operand_a = '0;
        operand_b = '0;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        sample_a = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0007};
        sample_b = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFD};
        // every function on a zero divisor and extreme operands; MUL and DIV also on overflow
        for (int f = 0; f < 8; f++)
            for (int i = 0; i < 3; i++)
                issue(f[2:0], sample_a[(f + i) % 4], sample_b[i]);
        issue(rvmd_pkg::FUNC_DIV, sample_a[3], sample_b[3]);
        gap(3);

        sent = 0;
        while (sent < 400)
        begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst; i++)
            begin
                issue(3'($urandom_range(0, 7)), pick_operand(), pick_operand());
                sent++;
            end
            if (sent > 200 && sent <= 200 + burst)
            begin
                start = 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            else if ($urandom_range(0, 3) != 0)
                gap($urandom_range(1, 8));
        end
        start = 1'b0;

        waited = 0;
        while (pending != 0 && waited < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
